/* rtl/stun_message_parser_macros.svh */
// Assertion helpers for the parser.
`ifndef STUN_MESSAGE_PARSER_MACROS_SVH
`define STUN_MESSAGE_PARSER_MACROS_SVH

`define SMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/smp_pkg.sv */
package smp_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_TID    = 3'd1,
    KIND_ATTR   = 3'd2,
    KIND_VALUE  = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_TOPBITS  = 4'd2,
    ST_COOKIE   = 4'd3,
    ST_ALIGN    = 4'd4,
    ST_SIZE     = 4'd5,
    ST_OVERRUN  = 4'd6,
    ST_FPMISS   = 4'd7,
    ST_FPBAD    = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_VAL  = 2'd1,
    PH_PAD  = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  localparam logic [0:0] CFG_CHECK_FP = 1'b0;
  localparam logic [0:0] CFG_ALLOW_MISSING = 1'b1;
  localparam int CfgW = 1;
  localparam logic [31:0] COOKIE = 32'h2112A442;
  localparam logic [15:0] FP_TYPE = 16'h8028;
  localparam logic [31:0] FP_XOR = 32'h5354554E;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [7:0] TOP_MASK = 8'hC0;
  localparam logic [15:0] ALIGN_MASK = 16'h0003;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;
  localparam int QDepth = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] message_type;
    logic [15:0] message_length;
    logic [15:0] attribute_type;
    logic [15:0] attribute_length;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [3:0]  status;
    logic        fingerprint_found;
    logic        last_of_run;
  } res_t;

  // Classified work entry: up to two results per byte
  typedef struct packed {
    logic  has_a;
    res_t  a;
    logic  has_b;
    res_t  b;
  } work_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

/* rtl/smp_stream_if.sv */
interface smp_stream_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/smp_front.sv */
module smp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [0:0]       cfg_data_i,
  input  logic             in_fire_i,
  input  smp_pkg::in_t     in_i,
  output smp_pkg::work_t   work_o
);

  logic [16:0] pos_q, pos_d;
  logic [15:0] htype_q, htype_d, hlen_q, hlen_d;
  logic [31:0] cookie_q, cookie_d, ahs_q, ahs_d;
  smp_pkg::phase_e ph_q, ph_d;
  logic [15:0] rem_q, rem_d;
  logic [1:0] pad_q, pad_d;
  logic [31:0] crc_q, crc_d, crcfp_q, crcfp_d, fpv_q, fpv_d;
  logic [2:0] fpf_q, fpf_d;
  logic [3:0] err_q, err_d;
  logic chk_q, allow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= 1'b1;
      allow_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == smp_pkg::CFG_CHECK_FP) chk_q <= cfg_data_i[0];
      else allow_q <= cfg_data_i[0];
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [16:0] body_end;
    logic [15:0] at, al;
    logic [3:0] st;
    logic [31:0] shifted;
    logic [17:0] sum;
    b = in_i.byte_value;
    body_end = 17'd20 + {1'b0, hlen_q};
    pos_d = pos_q; htype_d = htype_q; hlen_d = hlen_q; cookie_d = cookie_q;
    ahs_d = ahs_q; ph_d = ph_q; rem_d = rem_q; pad_d = pad_q;
    crcfp_d = crcfp_q; fpv_d = fpv_q; fpf_d = fpf_q; err_d = err_q;
    work_o = '0;
    at = ahs_q[31:16];
    al = ahs_q[15:0];
    shifted = {ahs_q[23:0], b};
    sum = '0;
    st = smp_pkg::ST_OK;
    if (pos_q < 17'd20) begin
      if (pos_q == 17'd0 && (b & smp_pkg::TOP_MASK) != 8'd0 &&
          (err_d == 4'd0 || smp_pkg::ST_TOPBITS < err_d)) err_d = smp_pkg::ST_TOPBITS;
      if (pos_q < 17'd2) htype_d = {htype_q[7:0], b};
      else if (pos_q < 17'd4) hlen_d = {hlen_q[7:0], b};
      else if (pos_q < 17'd8) cookie_d = {cookie_q[23:0], b};
      if (pos_q == 17'd3) begin
        if ((hlen_d & smp_pkg::ALIGN_MASK) != 16'd0 &&
            (err_d == 4'd0 || smp_pkg::ST_ALIGN < err_d)) err_d = smp_pkg::ST_ALIGN;
        work_o.has_a = 1'b1;
        work_o.a.kind = smp_pkg::KIND_HEADER;
        work_o.a.message_type = htype_d;
        work_o.a.message_length = hlen_d;
      end else if (pos_q == 17'd7) begin
        if (cookie_d != smp_pkg::COOKIE &&
            (err_d == 4'd0 || smp_pkg::ST_COOKIE < err_d)) err_d = smp_pkg::ST_COOKIE;
      end else if (pos_q >= 17'd8) begin
        work_o.has_a = 1'b1;
        work_o.a.kind = smp_pkg::KIND_TID;
        work_o.a.data_byte = b;
        work_o.a.byte_offset = 16'(pos_q - 17'd8);
      end
    end else if (pos_q < body_end && ph_q != smp_pkg::PH_STOP) begin
      case (ph_q)
        smp_pkg::PH_HDR: begin
          if (pos_q[1:0] == 2'd0) begin
            if ({1'b0, pos_q} + 18'd4 > {1'b0, body_end}) ph_d = smp_pkg::PH_STOP;
            else crcfp_d = crc_q;
          end
          if (ph_d == smp_pkg::PH_HDR) begin
            ahs_d = shifted;
            if (pos_q[1:0] == 2'd3) begin
              at = shifted[31:16];
              al = shifted[15:0];
              sum = {1'b0, pos_q} + 18'd1 + {2'b0, al};
              if (sum > {1'b0, body_end}) begin
                if (err_d == 4'd0 || smp_pkg::ST_OVERRUN < err_d)
                  err_d = smp_pkg::ST_OVERRUN;
                ph_d = smp_pkg::PH_STOP;
              end else begin
                work_o.has_a = 1'b1;
                work_o.a.kind = smp_pkg::KIND_ATTR;
                work_o.a.attribute_type = at;
                work_o.a.attribute_length = al;
                if (at == smp_pkg::FP_TYPE) begin
                  fpf_d = {al != 16'd4, 2'b11};
                  fpv_d = '0;
                end else begin
                  fpf_d = {2'b00, fpf_q[0]};
                end
                if (al != 16'd0) begin
                  ph_d = smp_pkg::PH_VAL;
                  rem_d = al;
                end
              end
            end
          end
        end
        smp_pkg::PH_VAL: begin
          work_o.has_a = 1'b1;
          work_o.a.kind = smp_pkg::KIND_VALUE;
          work_o.a.attribute_type = at;
          work_o.a.attribute_length = al;
          work_o.a.data_byte = b;
          work_o.a.byte_offset = al - rem_q;
          if (fpf_q[1]) fpv_d = {fpv_q[23:0], b};
          rem_d = rem_q - 16'd1;
          if (rem_d == 16'd0) begin
            pad_d = 2'(3'd4 - {1'b0, al[1:0]});
            ph_d = (pad_d != 2'd0) ? smp_pkg::PH_PAD : smp_pkg::PH_HDR;
          end
        end
        default: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) ph_d = smp_pkg::PH_HDR;
        end
      endcase
    end
    crc_d = smp_pkg::crc_byte(crc_q, b);
    if (pos_q < smp_pkg::POS_MAX) pos_d = pos_q + 17'd1;
    if (in_i.final_byte) begin
      if (pos_d < 17'd20) st = smp_pkg::ST_SHORT;
      else if (err_d >= 4'd2 && err_d <= 4'd4) st = err_d;
      else if (pos_d != body_end) st = smp_pkg::ST_SIZE;
      else if (err_d == smp_pkg::ST_OVERRUN) st = smp_pkg::ST_OVERRUN;
      else if (!chk_q) st = smp_pkg::ST_OK;
      else if (!fpf_d[0]) st = allow_q ? smp_pkg::ST_OK : smp_pkg::ST_FPMISS;
      else if (fpf_d[2:1] != 2'b01) st = smp_pkg::ST_FPBAD;
      else st = ((crcfp_d ^ 32'hFFFFFFFF) == (fpv_d ^ smp_pkg::FP_XOR)) ?
                smp_pkg::ST_OK : smp_pkg::ST_FPBAD;
      work_o.has_b = 1'b1;
      work_o.b.kind = smp_pkg::KIND_END;
      work_o.b.message_type = htype_d;
      work_o.b.message_length = hlen_d;
      work_o.b.status = st;
      work_o.b.fingerprint_found = fpf_d[0];
      work_o.b.last_of_run = 1'b1;
    end else begin
      work_o.a.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; htype_q <= '0; hlen_q <= '0; cookie_q <= '0; ahs_q <= '0;
      ph_q <= smp_pkg::PH_HDR; rem_q <= '0; pad_q <= '0; crc_q <= '1;
      crcfp_q <= '0; fpv_q <= '0; fpf_q <= '0; err_q <= '0;
    end else if (in_fire_i) begin
      if (in_i.final_byte) begin
        pos_q <= '0; htype_q <= '0; hlen_q <= '0; cookie_q <= '0; ahs_q <= '0;
        ph_q <= smp_pkg::PH_HDR; rem_q <= '0; pad_q <= '0; crc_q <= '1;
        crcfp_q <= '0; fpv_q <= '0; fpf_q <= '0; err_q <= '0;
      end else begin
        pos_q <= pos_d; htype_q <= htype_d; hlen_q <= hlen_d; cookie_q <= cookie_d;
        ahs_q <= ahs_d; ph_q <= ph_d; rem_q <= rem_d; pad_q <= pad_d;
        crc_q <= crc_d; crcfp_q <= crcfp_d; fpv_q <= fpv_d; fpf_q <= fpf_d;
        err_q <= err_d;
      end
    end
  end

endmodule

/* rtl/smp_back.sv */
`include "stun_message_parser_macros.svh"
module smp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  smp_pkg::work_t  work_i,
  output logic            full_o,
  smp_stream_if.source    out_if
);

  smp_pkg::work_t mem_q [smp_pkg::QDepth];
  logic [$clog2(smp_pkg::QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(smp_pkg::QDepth):0] cnt_q;
  logic sel_q;
  logic pop, fire, empty;
  smp_pkg::work_t head;

  assign empty = (cnt_q == '0);
  assign full_o = (cnt_q == ($clog2(smp_pkg::QDepth)+1)'(smp_pkg::QDepth));
  assign head = mem_q[rp_q];
  assign out_if.valid = !empty;
  assign out_if.payload = (sel_q || !head.has_a) ? head.b : head.a;
  assign fire = out_if.valid && out_if.ready;
  assign pop = fire && (sel_q || !head.has_a || !head.has_b);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sel_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      if (push_i && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push_i) cnt_q <= cnt_q - 1'b1;
      if (pop) sel_q <= 1'b0;
      else if (fire) sel_q <= 1'b1;
    end
  end

  `SMP_ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop)
  `SMP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= ($clog2(smp_pkg::QDepth)+1)'(smp_pkg::QDepth))
  `SMP_ASSERT_NEXT(a_sel_clear, pop, !sel_q)

endmodule

/* rtl/stun_message_parser.sv */
// channel | dir | payload
// in_if   | in  | byte_value[8:1], final_byte[0]
// out_if  | out | res_t (kind .. last_of_run)
// One byte accepted per cycle while the queue is not full; a byte yields up to two
// results, and a byte with two results presents them one after the other.
// The queue between classifier and output holds two entries; input ready drops
// only when it is full. Reset restores registers to defaults and empties the queue.
module stun_message_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  smp_stream_if.sink   in_if,
  smp_stream_if.source out_if
);

  smp_pkg::work_t work;
  smp_pkg::in_t in_item;
  logic full, fire;

  assign in_item = in_if.payload;
  assign in_if.ready = !full;
  assign fire = in_if.valid && in_if.ready;

  smp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_fire_i(fire), .in_i(in_item), .work_o(work)
  );

  smp_back u_back (
    .clk_i, .rst_ni, .push_i(fire && (work.has_a || work.has_b)), .work_i(work),
    .full_o(full), .out_if(out_if)
  );

endmodule
